### hdl/lud_pkg.sv
// ---------------------------------------------------------------------------
// Lens undistortion package
// Shared constants, codes and saturation helpers of the point undistortion
// block.
// ---------------------------------------------------------------------------
package lud_pkg;

   localparam int MAX_ITERATIONS = 100;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

   // Dividend magnitude of the normalization: |pixel*2^8 - c| * 2^28.
   localparam int DIV_W     = 61;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam logic signed [33:0] QONE = 34'sd268435456;

   typedef enum logic [1:0] {
      STATUS_CONVERGED  = 2'd0,
      STATUS_ITER_LIMIT = 2'd1,
      STATUS_NOT_CONFIG = 2'd2
   } status_type;

   localparam logic [7:0] CSR_FOCAL     = 8'd0;
   localparam logic [7:0] CSR_PRINCIPAL = 8'd1;
   localparam logic [7:0] CSR_SKEW      = 8'd2;
   localparam logic [7:0] CSR_K1        = 8'd3;
   localparam logic [7:0] CSR_K2        = 8'd4;
   localparam logic [7:0] CSR_K3        = 8'd5;
   localparam logic [7:0] CSR_P1        = 8'd6;
   localparam logic [7:0] CSR_P2        = 8'd7;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Maps a product of a focal length and a normalized value back to pixels.
   function automatic logic signed [23:0] to_pixel(input logic signed [36:0] p,
                                                   input logic signed [31:0] c);
      logic signed [37:0] t;
      logic signed [29:0] s;
      logic signed [23:0] r;
      t = 38'(p) + 38'(c);
      s = t[37:8];
      if (s > 30'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (s < -30'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = s[23:0];
      end
      return r;
   endfunction

endpackage

### hdl/lud_mul.sv
// ---------------------------------------------------------------------------
// Lens undistortion multiplier
// Shared signed multiplier with a registered result, floored to Q9.28.
// ---------------------------------------------------------------------------
module lud_mul (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [36:0] prod_ff
);
   logic signed [64:0] full;
   logic signed [36:0] prod_in;

   always_comb begin
      full    = 65'(op_a) * 65'(op_b);
      // Taking the upper bits of a two's complement product floors it.
      prod_in = full[64:28];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

### hdl/lud_div.sv
// ---------------------------------------------------------------------------
// Lens undistortion divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lud_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lud_pkg::DIV_W-1:0]  dividend,
   input  logic [31:0]                divisor,
   output logic                       done_ff,
   output logic [lud_pkg::DIV_W-1:0]  quot_ff
);
   import lud_pkg::*;

   logic                 busy_ff, busy_in, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIV_W-1:0]     quot_in;
   logic [32:0]          trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, quot_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         dsr_in  = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter below.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = 32'(trial - {1'b0, dsr_ff});
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end
endmodule

### hdl/lens_undistort_point.sv
// ---------------------------------------------------------------------------
// Lens undistortion of one pixel
// Normalizes a distorted pixel and inverts the radial and tangential lens
// model by fixed-point iteration on one shared multiplier.
// ---------------------------------------------------------------------------
// With a focal length of zero the pixel goes straight to the output; otherwise
// the two normalizing divisions run, then the skew term, the rounds of the
// iteration, denormalizing and the load of the output register.
// One item at a time: the next item is taken once the result is handed over
// to the output register, which holds it while the receiver stalls.
// Reset returns the sequencer to idle and clears the output valid and the lens registers to zero.
module lens_undistort_point (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_pixel_x,
   input  logic signed [23:0] req_pixel_y,
   input  logic [30:0]        req_limit_x,
   input  logic [30:0]        req_limit_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_corrected_x,
   output logic signed [23:0] rsp_corrected_y,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import lud_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIVY   = 7'b0000010,
      ST_DIVX   = 7'b0000100,
      ST_SKEW   = 7'b0001000,
      ST_ROUND  = 7'b0010000,
      ST_DENORM = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]        step_ff, step_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   logic [63:0] focal_ff, principal_ff;
   logic signed [31:0] skew_ff, k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   logic [31:0] fx, fy;
   logic signed [31:0] cx, cy;

   logic signed [23:0] px_ff, px_in, py_ff, py_in;
   logic [30:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [31:0] ny_ff, ny_in, nxa_ff, nxa_in, nx_ff, nx_in;
   logic signed [31:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [31:0] xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic signed [31:0] r2_ff, r2_in, r2x_ff, r2x_in, r2y_ff, r2y_in;
   logic signed [31:0] r4_ff, r4_in, r6_ff, r6_in;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [31:0] rad_ff, rad_in, t1_ff, t1_in, tx_ff, tx_in;
   logic signed [31:0] t3_ff, t3_in, ty_ff, ty_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, errx_ff, errx_in, erry_ff, erry_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [23:0] resx_ff, resx_in, resy_ff, resy_in;
   status_type         rest_ff, rest_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;

   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [36:0] mul_p;
   logic signed [31:0] mul_q;

   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dvd, div_quot;
   logic [31:0]        div_dsr;
   logic signed [33:0] diff;
   logic               neg_ff, neg_in;
   logic signed [31:0] quot_s;

   logic [32:0] abs_ex, abs_ey;
   logic        conv;

   assign fx = focal_ff[63:32];
   assign fy = focal_ff[31:0];
   assign cx = principal_ff[63:32];
   assign cy = principal_ff[31:0];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff     <= '0;
         principal_ff <= '0;
         skew_ff      <= '0;
         k1_ff        <= '0;
         k2_ff        <= '0;
         k3_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL:     focal_ff     <= csr_data;
            CSR_PRINCIPAL: principal_ff <= csr_data;
            CSR_SKEW:      skew_ff      <= csr_data[31:0];
            CSR_K1:        k1_ff        <= csr_data[31:0];
            CSR_K2:        k2_ff        <= csr_data[31:0];
            CSR_K3:        k3_ff        <= csr_data[31:0];
            CSR_P1:        p1_ff        <= csr_data[31:0];
            CSR_P2:        p2_ff        <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   lud_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   assign mul_q = sat32(40'(mul_p));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SKEW: begin
            mul_a = 33'(skew_ff);
            mul_b = ny_ff;
         end
         ST_ROUND: begin
            case (step_ff)
               5'd0: begin
                  mul_a = 33'(ex_ff);
                  mul_b = ex_ff;
               end
               5'd1: begin
                  mul_a = 33'(ey_ff);
                  mul_b = ey_ff;
               end
               5'd2: begin
                  mul_a = 33'(ex_ff);
                  mul_b = ey_ff;
               end
               5'd3: begin
                  mul_a = 33'(r2_ff);
                  mul_b = r2_ff;
               end
               // r4 is only registered at the end of step 4, so the k1 term
               // goes first and r6 is issued one step later.
               5'd4: begin
                  mul_a = 33'(k1_ff);
                  mul_b = r2_ff;
               end
               5'd5: begin
                  mul_a = 33'(r4_ff);
                  mul_b = r2_ff;
               end
               5'd6: begin
                  mul_a = 33'(k2_ff);
                  mul_b = r4_ff;
               end
               5'd7: begin
                  mul_a = 33'(k3_ff);
                  mul_b = r6_ff;
               end
               5'd8: begin
                  mul_a = 33'(p1_ff);
                  mul_b = xy_ff;
               end
               5'd9: begin
                  mul_a = 33'(p2_ff);
                  mul_b = r2x_ff;
               end
               5'd10: begin
                  mul_a = 33'(p1_ff);
                  mul_b = r2y_ff;
               end
               5'd11: begin
                  mul_a = 33'(p2_ff);
                  mul_b = xy_ff;
               end
               5'd12: begin
                  mul_a = 33'(rad_ff);
                  mul_b = ex_ff;
               end
               5'd13: begin
                  mul_a = 33'(rad_ff);
                  mul_b = ey_ff;
               end
               default: begin
               end
            endcase
         end
         ST_DENORM: begin
            case (step_ff)
               5'd0: begin
                  mul_a = 33'(skew_ff);
                  mul_b = ey_ff;
               end
               5'd1: begin
                  mul_a = $signed({1'b0, fy});
                  mul_b = ey_ff;
               end
               5'd2: begin
                  mul_a = $signed({1'b0, fx});
                  mul_b = tmp_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Divider operands: the y axis goes first, since x needs ny for skew.
   always_comb begin
      if (state_ff == ST_DIVY) begin
         diff    = 34'($signed({py_ff, 8'b0})) - 34'(cy);
         div_dsr = fy;
      end else begin
         diff    = 34'($signed({px_ff, 8'b0})) - 34'(cx);
         div_dsr = fx;
      end
      neg_in    = diff[33];
      div_dvd   = {(diff[33] ? 33'(-diff) : 33'(diff)), 28'b0};
      div_start = ((state_ff == ST_DIVY) || (state_ff == ST_DIVX)) && (step_ff == 5'd0);
   end

   lud_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done_ff  (div_done),
      .quot_ff  (div_quot)
   );

   // Truncating quotient with its sign restored, saturated to 32 bits.
   always_comb begin
      if (!neg_ff) begin
         quot_s = (div_quot > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                    : $signed(div_quot[31:0]);
      end else begin
         quot_s = (div_quot >= DIV_W'(33'h80000000)) ? 32'sh80000000
                                                     : $signed(-div_quot[31:0]);
      end
   end

   always_comb begin
      abs_ex = errx_ff[31] ? 33'(-33'(errx_ff)) : 33'(errx_ff);
      abs_ey = erry_ff[31] ? 33'(-33'(erry_ff)) : 33'(erry_ff);
      conv   = (abs_ex < {2'b0, lx_ff}) && (abs_ey < {2'b0, ly_ff});
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      iter_in  = iter_ff;
      px_in = px_ff;   py_in = py_ff;   lx_in = lx_ff;   ly_in = ly_ff;
      ny_in = ny_ff;   nxa_in = nxa_ff; nx_in = nx_ff;
      ex_in = ex_ff;   ey_in = ey_ff;
      xx_in = xx_ff;   yy_in = yy_ff;   xy_in = xy_ff;
      r2_in = r2_ff;   r2x_in = r2x_ff; r2y_in = r2y_ff;
      r4_in = r4_ff;   r6_in = r6_ff;   acc_in = acc_ff;  rad_in = rad_ff;
      t1_in = t1_ff;   tx_in = tx_ff;   t3_in = t3_ff;    ty_in = ty_ff;
      dx_in = dx_ff;   dy_in = dy_ff;   errx_in = errx_ff; erry_in = erry_ff;
      tmp_in = tmp_ff;
      resx_in = resx_ff; resy_in = resy_ff; rest_in = rest_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff; rsp_st_in = rsp_st_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in = req_pixel_x;
               py_in = req_pixel_y;
               lx_in = req_limit_x;
               ly_in = req_limit_y;
               step_in = 5'd0;
               if ((fx == 32'd0) || (fy == 32'd0)) begin
                  resx_in  = req_pixel_x;
                  resy_in  = req_pixel_y;
                  rest_in  = STATUS_NOT_CONFIG;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIVY;
               end
            end
         end
         ST_DIVY: begin
            step_in = 5'd1;
            if (step_ff == 5'd0) begin
               // The sign is latched with the start of each division.
               // (neg_ff is loaded below.)
            end
            if (div_done) begin
               ny_in    = quot_s;
               step_in  = 5'd0;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            step_in = 5'd1;
            if (div_done) begin
               nxa_in   = quot_s;
               step_in  = 5'd0;
               state_in = ST_SKEW;
            end
         end
         ST_SKEW: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd1) begin
               nx_in    = sat32(40'(nxa_ff) - 40'(mul_q));
               ex_in    = sat32(40'(nxa_ff) - 40'(mul_q));
               ey_in    = ny_ff;
               iter_in  = '0;
               step_in  = 5'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd1: xx_in = mul_q;
               5'd2: begin
                  yy_in = mul_q;
                  r2_in = sat32(40'(xx_ff) + 40'(mul_q));
               end
               5'd3: begin
                  xy_in  = mul_q;
                  r2x_in = sat32(40'(r2_ff) + 40'(xx_ff) + 40'(xx_ff));
                  r2y_in = sat32(40'(r2_ff) + 40'(yy_ff) + 40'(yy_ff));
               end
               5'd4: r4_in = mul_q;
               5'd5: acc_in = QONE + 34'(mul_q);
               5'd6: r6_in = mul_q;
               5'd7: acc_in = acc_ff + 34'(mul_q);
               5'd8: rad_in = sat32(40'(acc_ff) + 40'(mul_q));
               5'd9: t1_in = mul_q;
               5'd10: tx_in = sat32(40'(t1_ff) + 40'(t1_ff) + 40'(mul_q));
               5'd11: t3_in = mul_q;
               5'd12: ty_in = sat32(40'(t3_ff) + 40'(mul_q) + 40'(mul_q));
               5'd13: dx_in = sat32(40'(mul_q) + 40'(tx_ff));
               5'd14: begin
                  dy_in   = sat32(40'(mul_q) + 40'(ty_ff));
                  errx_in = sat32(40'(dx_ff) - 40'(nx_ff));
               end
               5'd15: begin
                  erry_in = sat32(40'(dy_ff) - 40'(ny_ff));
                  ex_in   = sat32(40'(ex_ff) - 40'(errx_ff));
               end
               5'd16: begin
                  ey_in   = sat32(40'(ey_ff) - 40'(erry_ff));
                  iter_in = iter_ff + 1'b1;
                  step_in = 5'd0;
                  if (conv) begin
                     state_in = ST_DENORM;
                  end else if (iter_ff == ITER_W'(MAX_ITERATIONS - 1)) begin
                     resx_in  = px_ff;
                     resy_in  = py_ff;
                     rest_in  = STATUS_ITER_LIMIT;
                     state_in = ST_OUT;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DENORM: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd1: tmp_in = sat32(40'(ex_ff) + 40'(mul_q));
               5'd2: resy_in = to_pixel(mul_p, cy);
               5'd3: begin
                  resx_in  = to_pixel(mul_p, cx);
                  rest_in  = STATUS_CONVERGED;
                  step_in  = 5'd0;
                  state_in = ST_OUT;
               end
               default: begin
               end
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = resx_ff;
               rsp_y_in     = resy_ff;
               rsp_st_in    = rest_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (div_start) begin
         neg_ff <= neg_in;
      end
      px_ff <= px_in;   py_ff <= py_in;   lx_ff <= lx_in;   ly_ff <= ly_in;
      ny_ff <= ny_in;   nxa_ff <= nxa_in; nx_ff <= nx_in;
      ex_ff <= ex_in;   ey_ff <= ey_in;
      xx_ff <= xx_in;   yy_ff <= yy_in;   xy_ff <= xy_in;
      r2_ff <= r2_in;   r2x_ff <= r2x_in; r2y_ff <= r2y_in;
      r4_ff <= r4_in;   r6_ff <= r6_in;   acc_ff <= acc_in;  rad_ff <= rad_in;
      t1_ff <= t1_in;   tx_ff <= tx_in;   t3_ff <= t3_in;    ty_ff <= ty_in;
      dx_ff <= dx_in;   dy_ff <= dy_in;   errx_ff <= errx_in; erry_ff <= erry_in;
      tmp_ff <= tmp_in;
      resx_ff <= resx_in; resy_ff <= resy_in; rest_ff <= rest_in;
      rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in; rsp_st_ff <= rsp_st_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corrected_x = rsp_x_ff;
   assign rsp_corrected_y = rsp_y_ff;
   assign rsp_status      = rsp_st_ff;
endmodule

### sim/tb_lens_undistort_point.sv
// ---------------------------------------------------------------------------
// Testbench for lens_undistort_point
// Drives distorted pixels through the undistortion block under several lens
// settings, predicts each corrected pixel and status in the bench, and
// compares every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_lens_undistort_point;
   timeunit 1ns;
   timeprecision 1ps;

   import lud_pkg::*;

   localparam longint Q_ONE = 64'sd268435456;
   localparam logic [7:0] CSR_UNUSED = 8'd200;

   typedef struct {
      logic signed [23:0] px;
      logic signed [23:0] py;
      status_type         st;
   } point_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [23:0] req_pixel_x = '0;
   logic signed [23:0] req_pixel_y = '0;
   logic [30:0]        req_limit_x = '0;
   logic [30:0]        req_limit_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_corrected_x;
   logic signed [23:0] rsp_corrected_y;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index = '0;
   logic [63:0]        csr_data = '0;

   // Lens settings as the bench believes the block holds them.
   logic [63:0] lens_focal = '0;
   logic [63:0] lens_center = '0;
   logic [31:0] lens_skew = '0;
   logic [31:0] lens_k1 = '0, lens_k2 = '0, lens_k3 = '0;
   logic [31:0] lens_p1 = '0, lens_p2 = '0;

   point_result_type pending_points[$];
   int            errors = 0;
   int            burst_left = 0;
   int            stall_run = 0;
   int            stall_mode = 0;

   lens_undistort_point uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return clamp32((a * b) >>> 28);
   endfunction

   function automatic longint s32(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic void apply_lens(input longint x, input longint y,
                                      output longint dx, output longint dy);
      longint xx, yy, xy, r2, r4, r6, rad, tx, ty;
      xx  = fmul(x, x);
      yy  = fmul(y, y);
      xy  = fmul(x, y);
      r2  = clamp32(xx + yy);
      r4  = fmul(r2, r2);
      r6  = fmul(r4, r2);
      rad = clamp32(Q_ONE + fmul(s32(lens_k1), r2) + fmul(s32(lens_k2), r4)
                    + fmul(s32(lens_k3), r6));
      tx  = clamp32(2 * fmul(s32(lens_p1), xy)
                    + fmul(s32(lens_p2), clamp32(r2 + 2 * xx)));
      ty  = clamp32(fmul(s32(lens_p1), clamp32(r2 + 2 * yy))
                    + 2 * fmul(s32(lens_p2), xy));
      dx  = clamp32(fmul(rad, x) + tx);
      dy  = clamp32(fmul(rad, y) + ty);
   endfunction

   function automatic longint back_to_pixel(longint f, longint q, longint c);
      return clamp24((((f * q) >>> 28) + c) >>> 8);
   endfunction

   function automatic point_result_type undistort(logic signed [23:0] pix_x,
                                                  logic signed [23:0] pix_y,
                                                  logic [30:0] lim_x,
                                                  logic [30:0] lim_y);
      point_result_type r;
      longint fx, fy, cx, cy, sk, nx, ny, ex, ey, dx, dy, errx, erry;
      bit     done;
      fx = longint'(lens_focal[63:32]);
      fy = longint'(lens_focal[31:0]);
      cx = s32(lens_center[63:32]);
      cy = s32(lens_center[31:0]);
      sk = s32(lens_skew);
      r.px = pix_x;
      r.py = pix_y;
      done = 0;
      if (fx == 0 || fy == 0) begin
         r.st = STATUS_NOT_CONFIG;
      end else begin
         ny = clamp32(((longint'(pix_y) * 256 - cy) * Q_ONE) / fy);
         nx = clamp32(clamp32(((longint'(pix_x) * 256 - cx) * Q_ONE) / fx)
                      - fmul(sk, ny));
         ex = nx;
         ey = ny;
         for (int i = 0; i < MAX_ITERATIONS && !done; i++) begin
            apply_lens(ex, ey, dx, dy);
            errx = clamp32(dx - nx);
            erry = clamp32(dy - ny);
            ex = clamp32(ex - errx);
            ey = clamp32(ey - erry);
            if ((errx < 0 ? -errx : errx) < longint'(lim_x) &&
                (erry < 0 ? -erry : erry) < longint'(lim_y))
               done = 1;
         end
         if (done) begin
            r.px = 24'(back_to_pixel(fx, clamp32(ex + fmul(sk, ey)), cx));
            r.py = 24'(back_to_pixel(fy, ey, cy));
            r.st = STATUS_CONVERGED;
         end else begin
            r.st = STATUS_ITER_LIMIT;
         end
      end
      return r;
   endfunction

   // Receiver stall pattern: runs of no stall, light stall and heavy stall.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run  = $urandom_range(1, 60);
      end
      stall_run--;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Result checker: every result transfer against the oldest prediction.
   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t: result with nothing expected: x=%0d y=%0d st=%0d",
                     $time, rsp_corrected_x, rsp_corrected_y, rsp_status);
            errors++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_corrected_x !== e.px) begin
               $display("%0t: corrected_x expected %0d actual %0d",
                        $time, e.px, rsp_corrected_x);
               errors++;
            end
            if (rsp_corrected_y !== e.py) begin
               $display("%0t: corrected_y expected %0d actual %0d",
                        $time, e.py, rsp_corrected_y);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, e.st, rsp_status);
               errors++;
            end
         end
      end
   end

   task automatic send_point(logic signed [23:0] pix_x, logic signed [23:0] pix_y,
                             logic [30:0] lim_x, logic [30:0] lim_y);
      req_valid   <= 1'b1;
      req_pixel_x <= pix_x;
      req_pixel_y <= pix_y;
      req_limit_x <= lim_x;
      req_limit_y <= lim_y;
      do @(posedge clock); while (req_stall);
      pending_points.push_back(undistort(pix_x, pix_y, lim_x, lim_y));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(0, 12);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      // A burst may still hold valid high; nothing more is offered while draining.
      req_valid <= 1'b0;
      wait (pending_points.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FOCAL:     lens_focal  = data;
         CSR_PRINCIPAL: lens_center = data;
         CSR_SKEW:      lens_skew   = data[31:0];
         CSR_K1:        lens_k1     = data[31:0];
         CSR_K2:        lens_k2     = data[31:0];
         CSR_K3:        lens_k3     = data[31:0];
         CSR_P1:        lens_p1     = data[31:0];
         CSR_P2:        lens_p2     = data[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_lens(logic [63:0] focal, logic [63:0] center, logic [31:0] sk,
                           logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                           logic [31:0] p1, logic [31:0] p2);
      // Random upper bits on the narrow registers must be dropped by the block.
      write_reg(CSR_FOCAL, focal);
      write_reg(CSR_PRINCIPAL, center);
      write_reg(CSR_SKEW, {$urandom(), sk});
      write_reg(CSR_K1, {$urandom(), k1});
      write_reg(CSR_K2, {$urandom(), k2});
      write_reg(CSR_K3, {$urandom(), k3});
      write_reg(CSR_P1, {$urandom(), p1});
      write_reg(CSR_P2, {$urandom(), p2});
   endtask

   task automatic test_not_configured();
      send_point(24'sh7FFFFF, 24'sh800000, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_point(24'sh800000, 24'sh7FFFFF, 31'd0, 31'd0);
      wait_drained();
      write_reg(CSR_FOCAL, {32'h0100_0000, 32'h0});
      send_point(24'sd1234, -24'sd999, 31'd4096, 31'd4096);
      wait_drained();
      write_reg(CSR_FOCAL, {32'h0, 32'h0100_0000});
      send_point(-24'sd77, 24'sd5, 31'd4096, 31'd4096);
      wait_drained();
   endtask

   task automatic test_identity_lens();
      set_lens({32'h0200_0000, 32'h0200_0000}, {32'h0140_0000, 32'h00F0_0000},
               32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_point(24'sd0, 24'sd0, 31'd1, 31'd1);
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_point(24'sh800000, 24'sh800000, 31'h7FFFFFFF, 31'h7FFFFFFF);
      // A zero limit can never be met.
      send_point(24'sd100, 24'sd100, 31'd0, 31'd1000);
      send_point(24'sd100, 24'sd100, 31'd1000, 31'd0);
      wait_drained();
      // Writes to an unused index must leave the lens untouched.
      write_reg(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_point(24'sd2560, -24'sd2560, 31'd1024, 31'd1024);
      wait_drained();
   endtask

   task automatic test_extreme_lens();
      set_lens(64'hFFFF_FFFF_FFFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000},
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF);
      send_point(24'sh7FFFFF, 24'sh800000, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_point(24'sd0, 24'sd0, 31'd16, 31'd16);
      wait_drained();
      set_lens({32'h0000_0001, 32'h0000_0001}, {32'h8000_0000, 32'h7FFF_FFFF},
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000);
      send_point(24'sh800000, 24'sh7FFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_point(24'sd1, -24'sd1, 31'h7FFFFFFF, 31'h7FFFFFFF);
      wait_drained();
   endtask

   function automatic logic [31:0] small_coeff(int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic test_random_lens(int phases, int per_phase);
      logic [30:0]        lx, ly;
      logic signed [23:0] px, py;
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         if (p % 4 == 3) begin
            set_lens({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         end else begin
            set_lens({16'($urandom_range(200, 3000)), 16'($urandom()),
                      16'($urandom_range(200, 3000)), 16'($urandom())},
                     {16'($urandom_range(0, 1000)), 16'($urandom()),
                      16'($urandom_range(0, 1000)), 16'($urandom())},
                     small_coeff(1 << 22), small_coeff(1 << 26), small_coeff(1 << 24),
                     small_coeff(1 << 22), small_coeff(1 << 23), small_coeff(1 << 23));
         end
         for (int n = 0; n < per_phase; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  px = 24'($urandom());
                  py = 24'($urandom());
               end
               default: begin
                  px = 24'($signed($urandom_range(0, 1 << 19)) - (1 << 17));
                  py = 24'($signed($urandom_range(0, 1 << 19)) - (1 << 17));
               end
            endcase
            case ($urandom_range(0, 9))
               0: begin
                  lx = 31'($urandom());
                  ly = 31'($urandom());
               end
               1: begin
                  lx = 31'($urandom_range(0, 1));
                  ly = 31'($urandom_range(0, 8));
               end
               default: begin
                  lx = 31'($urandom_range(1 << 8, 1 << 22));
                  ly = 31'($urandom_range(1 << 8, 1 << 22));
               end
            endcase
            send_point(px, py, lx, ly);
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_configured();
      test_identity_lens();
      test_extreme_lens();
      test_random_lens(8, 150);
      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_points.size() == 0) begin
         $display("PASS lens_undistort_point");
      end else begin
         $display("FAIL lens_undistort_point");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("FAIL lens_undistort_point");
      $finish;
   end

endmodule
